FILE: rtl/token_lexer_stream_unit_macros.svh
// Assertion helpers for the scanner RTL.
`ifndef TOKEN_LEXER_STREAM_UNIT_MACROS_SVH
`define TOKEN_LEXER_STREAM_UNIT_MACROS_SVH

// Same-cycle implication.
`define TLS_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("scanner assertion failed");

// Next-cycle implication.
`define TLS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("scanner assertion failed");

`endif

FILE: rtl/tls_pkg.sv
package tls_pkg;

   localparam int unsigned DEF_OFFSET_BITS = 20;
   localparam int unsigned DEF_LINE_BITS   = 16;
   localparam int unsigned DEF_COLUMN_BITS = 16;

   localparam int unsigned OUT_OFFSET_W = 20;
   localparam int unsigned OUT_LINE_W   = 16;
   localparam int unsigned OUT_COLUMN_W = 16;
   localparam int unsigned KIND_W       = 5;
   localparam int unsigned ERR_W        = 2;
   localparam int unsigned VALUE_W      = 31;
   localparam int unsigned PREFIX_W     = 48;

   localparam int unsigned MAX_RESULTS  = 3;
   localparam int unsigned QUEUE_DEPTH  = 8;
   localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_NONE     = 5'd0;
   localparam logic [KIND_W-1:0] KIND_DOT      = 5'd7;
   localparam logic [KIND_W-1:0] KIND_STRING   = 5'd16;
   localparam logic [KIND_W-1:0] KIND_INT      = 5'd17;
   localparam logic [KIND_W-1:0] KIND_FLOAT    = 5'd18;
   localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd19;
   localparam logic [KIND_W-1:0] KIND_KW_FIRST = 5'd20;
   localparam logic [KIND_W-1:0] KIND_END      = 5'd29;

   localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 2'd2;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   localparam logic [VALUE_W-1:0] INT_TOP = 31'h7FFF_FFFF;

   localparam logic [7:0] PUNCT_CHARS [16] = '{
      "(", ")", "[", "]", "<", ">", ",", ".", ";", ":", "+", "-", "*", CH_AT, "/", "="
   };

   // Keyword text is stored first character in the low byte.
   localparam logic [PREFIX_W-1:0] KW_TEXT [9] = '{
      48'("esle"), 48'("rof"), 48'("23f"), 48'("fi"), 48'("23i"),
      48'("tnirp"), 48'("rosnet"), 48'("rav"), 48'("elihw")
   };
   localparam logic [2:0] KW_LEN [9] = '{3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd5, 3'd6, 3'd3, 3'd5};

   typedef struct packed {
      logic [KIND_W-1:0]       token_kind;
      logic [ERR_W-1:0]        error_code;
      logic [OUT_OFFSET_W-1:0] start_offset;
      logic [OUT_OFFSET_W-1:0] token_length;
      logic [OUT_LINE_W-1:0]   token_line;
      logic [OUT_COLUMN_W-1:0] token_column;
      logic [VALUE_W-1:0]      int_value;
      logic                    last_result;
   } rsp_item_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0]                valid;
      rsp_item_type [MAX_RESULTS-1:0]        item;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } punct_type;

   function automatic logic digit_char(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic letter_char(input logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == CH_UNDER);
   endfunction

   function automatic punct_type punct_lookup(input logic [7:0] b);
      punct_type r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         if (b == PUNCT_CHARS[i]) begin
            r.hit = 1'b1;
            r.idx = 4'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [KIND_W-1:0] keyword_kind(input logic [PREFIX_W-1:0] prefix,
                                                      input logic [2:0] len);
      logic [KIND_W-1:0] k;
      k = KIND_IDENT;
      for (int i = 0; i < 9; i++) begin
         if ((len == KW_LEN[i]) && (prefix == KW_TEXT[i])) begin
            k = KIND_KW_FIRST + KIND_W'(i);
         end
      end
      return k;
   endfunction

endpackage

FILE: rtl/tls_req_if.sv
interface tls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_input;

   modport source (output valid, source_byte, end_of_input, input ready);
   modport sink   (input valid, source_byte, end_of_input, output ready);
endinterface

FILE: rtl/tls_rsp_if.sv
interface tls_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tls_pkg::KIND_W-1:0]       token_kind;
   logic [tls_pkg::ERR_W-1:0]        error_code;
   logic [tls_pkg::OUT_OFFSET_W-1:0] start_offset;
   logic [tls_pkg::OUT_OFFSET_W-1:0] token_length;
   logic [tls_pkg::OUT_LINE_W-1:0]   token_line;
   logic [tls_pkg::OUT_COLUMN_W-1:0] token_column;
   logic [tls_pkg::VALUE_W-1:0]      int_value;
   logic                             last_result;

   modport source (output valid, token_kind, error_code, start_offset, token_length,
                   token_line, token_column, int_value, last_result, input ready);
   modport sink   (input valid, token_kind, error_code, start_offset, token_length,
                   token_line, token_column, int_value, last_result, output ready);
endinterface

FILE: rtl/tls_result_queue.sv
module tls_result_queue (
   input  logic               clock,
   input  logic               reset,
   input  tls_pkg::push_type  push,
   output logic               queue_room,
   tls_rsp_if.source          rsp_chan
);
   import tls_pkg::*;

   rsp_item_type               mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]        count_ff, count_in;
   logic [QUEUE_AW-1:0]        slot_off [MAX_RESULTS];
   logic [QUEUE_CW-1:0]        push_n;
   logic                       pop;
   rsp_item_type               head;

   always_comb begin
      push_n = '0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         slot_off[k] = QUEUE_AW'(push_n);
         push_n      = push_n + QUEUE_CW'(push.valid[k]);
      end
   end

   assign pop        = rsp_chan.valid && rsp_chan.ready;
   assign queue_room = count_ff <= QUEUE_CW'(QUEUE_DEPTH - MAX_RESULTS);
   assign wr_ptr_in  = wr_ptr_ff + QUEUE_AW'(push_n);
   assign rd_ptr_in  = rd_ptr_ff + QUEUE_AW'(pop);
   assign count_in   = count_ff + push_n - QUEUE_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (push.valid[k]) begin
            mem[wr_ptr_ff + slot_off[k]] <= push.item[k];
         end
      end
   end

   assign head                  = mem[rd_ptr_ff];
   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.token_kind   = head.token_kind;
   assign rsp_chan.error_code   = head.error_code;
   assign rsp_chan.start_offset = head.start_offset;
   assign rsp_chan.token_length = head.token_length;
   assign rsp_chan.token_line   = head.token_line;
   assign rsp_chan.token_column = head.token_column;
   assign rsp_chan.int_value    = head.int_value;
   assign rsp_chan.last_result  = head.last_result;

endmodule

FILE: rtl/tls_scan_core.sv
`include "token_lexer_stream_unit_macros.svh"

module tls_scan_core #(
   parameter int unsigned OFFSET_BITS = tls_pkg::DEF_OFFSET_BITS,
   parameter int unsigned LINE_BITS   = tls_pkg::DEF_LINE_BITS,
   parameter int unsigned COLUMN_BITS = tls_pkg::DEF_COLUMN_BITS
) (
   input  logic               clock,
   input  logic               reset,
   tls_req_if.sink            req_chan,
   input  logic               queue_room,
   output tls_pkg::push_type  push
);
   import tls_pkg::*;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_STRING  = 3'd2;
   localparam logic [2:0] MODE_INT     = 3'd3;
   localparam logic [2:0] MODE_DOT     = 3'd4;
   localparam logic [2:0] MODE_FRAC    = 3'd5;
   localparam logic [2:0] MODE_WORD    = 3'd6;

   localparam int unsigned SLOT_PEND = 0;
   localparam int unsigned SLOT_DOT  = 1;
   localparam int unsigned SLOT_LAST = 2;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] off;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
   } pos_type;

   localparam pos_type POS_RESET = '{off: '0, line: LINE_BITS'(1), col: COLUMN_BITS'(1)};

   function automatic pos_type step_pos(input pos_type p, input logic newline);
      pos_type r;
      r.off = p.off + OFFSET_BITS'(1);
      if (newline) begin
         r.line = (p.line != '1) ? p.line + LINE_BITS'(1) : p.line;
         r.col  = COLUMN_BITS'(1);
      end else begin
         r.line = p.line;
         r.col  = (p.col != '1) ? p.col + COLUMN_BITS'(1) : p.col;
      end
      return r;
   endfunction

   // input register
   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_end_ff;

   // scanner state
   logic [2:0]          mode_ff, mode_in;
   pos_type             cur_ff, cur_in;
   pos_type             start_ff, start_in;
   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic [2:0]          wlen_ff, wlen_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic                ovf_ff, ovf_in;

   logic                adv;
   logic [7:0]          b;
   logic                fin, dig, alpha, alnum, nl, ws, quote;
   punct_type           pt;
   pos_type             p1, p2;
   logic                consume, starts;
   logic [OFFSET_BITS-1:0] span_len, str_len;
   logic [VALUE_W-1:0]  int_val;
   logic [VALUE_W+3:0]  acc_next;
   logic [MAX_RESULTS-1:0] slot_valid, last_vec;
   rsp_item_type        slot [MAX_RESULTS];

   assign adv            = in_valid_ff && queue_room;
   assign req_chan.ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.source_byte;
         in_end_ff  <= req_chan.end_of_input;
      end
   end

   assign b     = in_byte_ff;
   assign fin   = in_end_ff;
   assign dig   = digit_char(b);
   assign alpha = letter_char(b);
   assign alnum = alpha || dig;
   assign nl    = b == CH_NEWLINE;
   assign ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || nl;
   assign quote = (b == CH_SQUOTE) || (b == CH_DQUOTE);
   assign pt    = punct_lookup(b);

   // a held dot takes its column before the current byte does
   assign p1       = (mode_ff == MODE_DOT) ? step_pos(cur_ff, 1'b0) : cur_ff;
   assign p2       = step_pos(p1, nl);
   assign consume  = !((mode_ff == MODE_INT) && (b == CH_DOT));
   assign span_len = cur_ff.off - start_ff.off;
   assign str_len  = p2.off - start_ff.off;
   assign int_val  = ovf_ff ? '0 : acc_ff;
   assign acc_next = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + (VALUE_W + 4)'(b[3:0]);

   always_comb begin
      case (mode_ff)
         MODE_IDLE:    starts = 1'b1;
         MODE_COMMENT: starts = nl;
         MODE_INT:     starts = !dig && (b != CH_DOT);
         MODE_DOT:     starts = !dig;
         MODE_FRAC:    starts = !dig;
         MODE_WORD:    starts = !alnum;
         default:      starts = 1'b0;
      endcase
      starts = starts && !fin;
   end

   // pending token, held dot, then the new punctuator, error or end token
   always_comb begin
      slot_valid = '0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         slot[k] = '0;
      end

      slot[SLOT_PEND].start_offset = OUT_OFFSET_W'(start_ff.off);
      slot[SLOT_PEND].token_line   = OUT_LINE_W'(start_ff.line);
      slot[SLOT_PEND].token_column = OUT_COLUMN_W'(start_ff.col);
      slot[SLOT_PEND].token_length = OUT_OFFSET_W'(span_len);
      case (mode_ff)
         MODE_INT, MODE_DOT: begin
            slot_valid[SLOT_PEND]      = fin || !dig && !((mode_ff == MODE_INT) && (b == CH_DOT));
            slot[SLOT_PEND].token_kind = KIND_INT;
            slot[SLOT_PEND].int_value  = int_val;
         end
         MODE_FRAC: begin
            slot_valid[SLOT_PEND]      = fin || !dig;
            slot[SLOT_PEND].token_kind = KIND_FLOAT;
         end
         MODE_WORD: begin
            slot_valid[SLOT_PEND]      = fin || !alnum;
            slot[SLOT_PEND].token_kind = keyword_kind(prefix_ff, wlen_ff);
         end
         MODE_STRING: begin
            if (fin) begin
               slot_valid[SLOT_PEND]      = 1'b1;
               slot[SLOT_PEND].error_code = ERR_UNTERMINATED;
            end else begin
               slot_valid[SLOT_PEND]        = b == CH_DQUOTE;
               slot[SLOT_PEND].token_kind   = KIND_STRING;
               slot[SLOT_PEND].token_length = OUT_OFFSET_W'(str_len);
            end
         end
         default: slot_valid[SLOT_PEND] = 1'b0;
      endcase

      slot_valid[SLOT_DOT]         = (mode_ff == MODE_DOT) && (fin || !dig);
      slot[SLOT_DOT].token_kind    = KIND_DOT;
      slot[SLOT_DOT].start_offset  = OUT_OFFSET_W'(cur_ff.off);
      slot[SLOT_DOT].token_line    = OUT_LINE_W'(cur_ff.line);
      slot[SLOT_DOT].token_column  = OUT_COLUMN_W'(cur_ff.col);
      slot[SLOT_DOT].token_length  = OUT_OFFSET_W'(1);

      slot[SLOT_LAST].start_offset = OUT_OFFSET_W'(p1.off);
      slot[SLOT_LAST].token_line   = OUT_LINE_W'(p1.line);
      slot[SLOT_LAST].token_column = OUT_COLUMN_W'(p1.col);
      if (fin) begin
         slot_valid[SLOT_LAST]      = 1'b1;
         slot[SLOT_LAST].token_kind = KIND_END;
      end else begin
         slot_valid[SLOT_LAST] = starts && (pt.hit ||
                                 !(ws || (b == CH_HASH) || quote || dig || alpha));
         slot[SLOT_LAST].token_length = OUT_OFFSET_W'(1);
         slot[SLOT_LAST].token_kind   = pt.hit ? KIND_W'(pt.idx) : KIND_NONE;
         slot[SLOT_LAST].error_code   = pt.hit ? ERR_NONE : ERR_UNEXPECTED;
      end

      slot_valid = adv ? slot_valid : '0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         last_vec[k] = slot_valid[k];
         for (int j = k + 1; j < MAX_RESULTS; j++) begin
            last_vec[k] = last_vec[k] && !slot_valid[j];
         end
         slot[k].last_result = last_vec[k];
         push.item[k]        = slot[k];
      end
      push.valid = slot_valid;
   end

   always_comb begin
      mode_in   = mode_ff;
      cur_in    = cur_ff;
      start_in  = start_ff;
      prefix_in = prefix_ff;
      wlen_in   = wlen_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      if (fin) begin
         // close the run: back to the reset state
         mode_in   = MODE_IDLE;
         cur_in    = POS_RESET;
         start_in  = POS_RESET;
         prefix_in = '0;
         wlen_in   = '0;
         acc_in    = '0;
         ovf_in    = 1'b0;
      end else begin
         cur_in = consume ? p2 : p1;
         if (starts) begin
            start_in = p1;
            mode_in  = MODE_IDLE;
            if (b == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (quote) begin
               mode_in = MODE_STRING;
            end else if (dig) begin
               mode_in = MODE_INT;
               acc_in  = VALUE_W'(b[3:0]);
               ovf_in  = 1'b0;
            end else if (alpha) begin
               mode_in   = MODE_WORD;
               prefix_in = PREFIX_W'(b);
               wlen_in   = 3'd1;
            end
         end else begin
            case (mode_ff)
               MODE_STRING: begin
                  if (b == CH_DQUOTE) mode_in = MODE_IDLE;
               end
               MODE_INT: begin
                  if (b == CH_DOT) begin
                     mode_in = MODE_DOT;
                  end else if (!ovf_ff) begin
                     if (acc_next[VALUE_W+3:VALUE_W] != '0) begin
                        ovf_in = 1'b1;
                        acc_in = '0;
                     end else begin
                        acc_in = acc_next[VALUE_W-1:0];
                     end
                  end
               end
               MODE_DOT: mode_in = MODE_FRAC;
               MODE_WORD: begin
                  if (wlen_ff < 3'd6) prefix_in[{wlen_ff, 3'b000} +: 8] = b;
                  if (wlen_ff != 3'd7) wlen_in = wlen_ff + 3'd1;
               end
               default: mode_in = mode_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         cur_ff    <= POS_RESET;
         start_ff  <= POS_RESET;
         prefix_ff <= '0;
         wlen_ff   <= '0;
         acc_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else if (adv) begin
         mode_ff   <= mode_in;
         cur_ff    <= cur_in;
         start_ff  <= start_in;
         prefix_ff <= prefix_in;
         wlen_ff   <= wlen_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
      end
   end

   `TLS_ASSERT_NEXT(a_end_clears, clock, reset, adv && in_end_ff,
                    (mode_ff == MODE_IDLE) && (cur_ff == POS_RESET))
   `TLS_ASSERT_NEXT(a_pos_holds, clock, reset, !adv,
                    $stable(cur_ff) && $stable(mode_ff))
   `TLS_ASSERT_NOW(a_end_token, clock, reset, adv && in_end_ff,
                   push.valid[SLOT_LAST] && (push.item[SLOT_LAST].token_kind == KIND_END))
   `TLS_ASSERT_NOW(a_dot_after_int, clock, reset, push.valid[SLOT_DOT],
                   push.valid[SLOT_PEND] && (push.item[SLOT_PEND].token_kind == KIND_INT))
   `TLS_ASSERT_NOW(a_one_last, clock, reset, push.valid != '0, $onehot(last_vec))

endmodule

FILE: rtl/token_lexer_stream_unit.sv
// Channel   Dir  Handshake      Carries
// req_chan  in   valid/ready    source_byte, end_of_input
// rsp_chan  out  valid/ready    token_kind, error_code, span, position, int_value, last_result
//
// One byte is taken per cycle while the result queue has room; each byte is scanned from the input register.
// Each byte writes 0 to 3 tokens into an 8-entry result queue; its tokens pass through the
// input register and then the queue before they show on rsp_chan.
// The input stalls only while the queue has fewer than 3 free entries.
// Synchronous reset clears the scanner state and empties the queue; no clearing pass.
// An end_of_input item flushes the pending token, emits the end token and restarts the run.
module token_lexer_stream_unit #(
   parameter int unsigned OFFSET_BITS = tls_pkg::DEF_OFFSET_BITS,
   parameter int unsigned LINE_BITS   = tls_pkg::DEF_LINE_BITS,
   parameter int unsigned COLUMN_BITS = tls_pkg::DEF_COLUMN_BITS
) (
   input  logic      clock,
   input  logic      reset,
   tls_req_if.sink   req_chan,
   tls_rsp_if.source rsp_chan
);
   import tls_pkg::*;

   push_type push;
   logic     queue_room;

   tls_scan_core #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_room (queue_room),
      .push       (push)
   );

   tls_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: tb/token_stream_check.sv
module token_stream_check (
   input  logic clock,
   input  logic reset,
   tls_req_if   req,
   tls_rsp_if   rsp,
   output int   fail_count,
   output int   pending_count,
   output int   token_count
);
   import tls_pkg::*;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_COMMENT, SCAN_STRING, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_WORD
   } scan_mode_e;

   localparam logic [63:0] INT_LIMIT = 64'h7FFF_FFFF;

   string keyword_names [9] = '{"else", "for", "f32", "if", "i32", "print", "tensor", "var",
                                "while"};

   scan_mode_e                mode;
   logic [OUT_OFFSET_W-1:0]   pos_offset, tok_offset;
   logic [OUT_LINE_W-1:0]     pos_line, tok_line;
   logic [OUT_COLUMN_W-1:0]   pos_column, tok_column;
   logic [PREFIX_W-1:0]       word_text;
   logic [2:0]                word_len;
   logic [31:0]               int_acc;
   logic                      int_ovf;

   rsp_item_type tokens_due [$];
   rsp_item_type step_tokens [$];
   int mismatches = 0;
   int compared = 0;

   function automatic logic decimal_digit(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic name_start(logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == CH_UNDER);
   endfunction

   function automatic int punct_index(logic [7:0] b);
      int r;
      r = -1;
      for (int i = 0; i < 16; i++) begin
         if (b == PUNCT_CHARS[i]) r = i;
      end
      return r;
   endfunction

   // Pack text with the first character in the low byte.
   function automatic logic [PREFIX_W-1:0] spell(string s);
      logic [PREFIX_W-1:0] r;
      r = '0;
      for (int i = 0; i < s.len(); i++) r[8*i +: 8] = s[i];
      return r;
   endfunction

   function automatic void restart();
      mode = SCAN_IDLE;
      pos_offset = '0;
      pos_line = OUT_LINE_W'(1);
      pos_column = OUT_COLUMN_W'(1);
      tok_offset = '0;
      tok_line = OUT_LINE_W'(1);
      tok_column = OUT_COLUMN_W'(1);
      word_text = '0;
      word_len = '0;
      int_acc = '0;
      int_ovf = 1'b0;
   endfunction

   function automatic void move_past(logic [7:0] b);
      pos_offset = pos_offset + OUT_OFFSET_W'(1);
      if (b == CH_NEWLINE) begin
         if (pos_line != '1) pos_line = pos_line + OUT_LINE_W'(1);
         pos_column = OUT_COLUMN_W'(1);
      end else if (pos_column != '1) begin
         pos_column = pos_column + OUT_COLUMN_W'(1);
      end
   endfunction

   function automatic void queue_token(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
                                       logic [OUT_OFFSET_W-1:0] off,
                                       logic [OUT_OFFSET_W-1:0] len,
                                       logic [OUT_LINE_W-1:0] line,
                                       logic [OUT_COLUMN_W-1:0] col,
                                       logic [VALUE_W-1:0] val);
      rsp_item_type t;
      if (step_tokens.size() >= MAX_RESULTS) return;
      t.token_kind = kind;
      t.error_code = err;
      t.start_offset = off;
      t.token_length = len;
      t.token_line = line;
      t.token_column = col;
      t.int_value = val;
      t.last_result = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void add_span(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
                                    logic [VALUE_W-1:0] val);
      queue_token(kind, err, tok_offset, pos_offset - tok_offset, tok_line, tok_column, val);
   endfunction

   function automatic void add_int();
      add_span(KIND_INT, ERR_NONE, int_ovf ? '0 : int_acc[VALUE_W-1:0]);
   endfunction

   function automatic void add_word();
      logic [KIND_W-1:0] kind;
      kind = KIND_IDENT;
      for (int i = 0; i < 9; i++) begin
         if ((int'(word_len) == keyword_names[i].len()) && (word_text == spell(keyword_names[i])))
            kind = KIND_KW_FIRST + KIND_W'(i);
      end
      add_span(kind, ERR_NONE, '0);
   endfunction

   // The held dot sits at the current position, which has not moved past it yet.
   function automatic void add_held_dot();
      queue_token(KIND_DOT, ERR_NONE, pos_offset, OUT_OFFSET_W'(1), pos_line, pos_column, '0);
      move_past(CH_DOT);
   endfunction

   function automatic void open_token(logic [7:0] b);
      int p;
      p = punct_index(b);
      mode = SCAN_IDLE;
      tok_offset = pos_offset;
      tok_line = pos_line;
      tok_column = pos_column;
      move_past(b);
      if (p >= 0) begin
         add_span(KIND_W'(p), ERR_NONE, '0);
         return;
      end
      if ((b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NEWLINE)) return;
      if (b == CH_HASH) begin
         mode = SCAN_COMMENT;
         return;
      end
      if ((b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
         mode = SCAN_STRING;
         return;
      end
      if (decimal_digit(b)) begin
         mode = SCAN_INT;
         int_acc = 32'(b) - 32'h30;
         int_ovf = 1'b0;
         return;
      end
      if (name_start(b)) begin
         mode = SCAN_WORD;
         word_text = PREFIX_W'(b);
         word_len = 3'd1;
         return;
      end
      add_span(KIND_NONE, ERR_UNEXPECTED, '0);
   endfunction

   function automatic void scan_item(logic [7:0] b, logic eoi);
      logic [63:0] v;
      step_tokens.delete();
      if (eoi) begin
         case (mode)
            SCAN_INT: add_int();
            SCAN_DOT: begin
               add_int();
               add_held_dot();
            end
            SCAN_FRAC: add_span(KIND_FLOAT, ERR_NONE, '0);
            SCAN_WORD: add_word();
            SCAN_STRING: add_span(KIND_NONE, ERR_UNTERMINATED, '0);
            default: ;
         endcase
         queue_token(KIND_END, ERR_NONE, pos_offset, '0, pos_line, pos_column, '0);
         restart();
      end else begin
         case (mode)
            SCAN_COMMENT: begin
               if (b == CH_NEWLINE) open_token(b);
               else move_past(b);
            end
            SCAN_STRING: begin
               move_past(b);
               if (b == CH_DQUOTE) begin
                  add_span(KIND_STRING, ERR_NONE, '0);
                  mode = SCAN_IDLE;
               end
            end
            SCAN_INT: begin
               if (decimal_digit(b)) begin
                  move_past(b);
                  if (!int_ovf) begin
                     v = 64'(int_acc) * 64'd10 + 64'(b) - 64'h30;
                     if (v > INT_LIMIT) begin
                        int_ovf = 1'b1;
                        v = '0;
                     end
                     int_acc = v[31:0];
                  end
               end else if (b == CH_DOT) begin
                  mode = SCAN_DOT;
               end else begin
                  add_int();
                  open_token(b);
               end
            end
            SCAN_DOT: begin
               if (decimal_digit(b)) begin
                  move_past(CH_DOT);
                  move_past(b);
                  mode = SCAN_FRAC;
               end else begin
                  add_int();
                  add_held_dot();
                  open_token(b);
               end
            end
            SCAN_FRAC: begin
               if (decimal_digit(b)) begin
                  move_past(b);
               end else begin
                  add_span(KIND_FLOAT, ERR_NONE, '0);
                  open_token(b);
               end
            end
            SCAN_WORD: begin
               if (name_start(b) || decimal_digit(b)) begin
                  move_past(b);
                  if (word_len < 6) word_text[8*word_len +: 8] = b;
                  if (word_len < 7) word_len = word_len + 3'd1;
               end else begin
                  add_word();
                  open_token(b);
               end
            end
            default: open_token(b);
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_result = 1'b1;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
   endfunction

   function automatic void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: token %0d %s expected %0d, got %0d", $time, compared, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         restart();
         tokens_due.delete();
      end else begin
         if (req.valid && req.ready) scan_item(req.source_byte, req.end_of_input);
         if (rsp.valid && rsp.ready) begin
            if (tokens_due.size() == 0) begin
               mismatches++;
               $display("%0t: token expected none, got kind %0d error %0d offset %0d",
                        $time, rsp.token_kind, rsp.error_code, rsp.start_offset);
            end else begin
               want = tokens_due.pop_front();
               compared++;
               check_field("token_kind", 64'(want.token_kind), 64'(rsp.token_kind));
               check_field("error_code", 64'(want.error_code), 64'(rsp.error_code));
               check_field("start_offset", 64'(want.start_offset), 64'(rsp.start_offset));
               check_field("token_length", 64'(want.token_length), 64'(rsp.token_length));
               check_field("token_line", 64'(want.token_line), 64'(rsp.token_line));
               check_field("token_column", 64'(want.token_column), 64'(rsp.token_column));
               check_field("int_value", 64'(want.int_value), 64'(rsp.int_value));
               check_field("last_result", 64'(want.last_result), 64'(rsp.last_result));
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= tokens_due.size();
      token_count <= compared;
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import tls_pkg::*;

   localparam int ITEM_TARGET = 410;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;

   logic clock;
   logic reset;

   tls_req_if req_chan ();
   tls_rsp_if rsp_chan ();

   int fail_count;
   int pending_count;
   int token_count;
   int bytes_sent = 0;
   int ends_sent = 0;
   int tokens_taken = 0;
   int req_mode = 0;
   int rsp_mode = 0;

   string punct_text = "()[]<>,.;:+-*@/=";
   string space_text = " \t\r\n";
   string name_text = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string keyword_pool [9] = '{"else", "for", "f32", "if", "i32", "print", "tensor", "var",
                               "while"};

   token_lexer_stream_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   token_stream_check u_token_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .token_count   (token_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_item(input logic [7:0] b, input logic eoi);
      int gap;
      // Redraw the idle style now and then so quiet stretches appear too.
      if ((bytes_sent + ends_sent) % 30 == 0) req_mode = $urandom_range(2, 0);
      gap = (req_mode == 0) ? 0 : $urandom_range(13, 0);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.source_byte <= b;
      req_chan.end_of_input <= eoi;
      do @(posedge clock); while (!req_chan.ready);
      if (eoi) ends_sent++;
      else bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(255, 0)), 1'b1);
   endtask

   task automatic send_digits(input int count);
      for (int i = 0; i < count; i++) send_item("0" + 8'($urandom_range(9, 0)), 1'b0);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) send_item(8'($urandom_range(255, 0)), 1'b0);
   endtask

   task automatic send_random_token();
      int pick;
      int count;
      int pos;
      string word;
      pick = $urandom_range(15, 0);
      case (pick)
         0, 1: send_item(punct_text[$urandom_range(15, 0)], 1'b0);
         2: send_item(space_text[$urandom_range(3, 0)], 1'b0);
         3: begin
            send_item(CH_HASH, 1'b0);
            send_noise($urandom_range(5, 0));
            send_item(CH_NEWLINE, 1'b0);
         end
         4: begin
            send_item($urandom_range(1, 0) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
            count = $urandom_range(6, 0);
            for (int i = 0; i < count; i++) begin
               if ($urandom_range(3, 0) == 0) send_item(CH_NEWLINE, 1'b0);
               else send_noise(1);
            end
            // Leave some strings open so an end marker finds them unterminated.
            if ($urandom_range(5, 0) != 0) send_item(CH_DQUOTE, 1'b0);
         end
         5, 6: begin
            case ($urandom_range(5, 0))
               0: send_text("2147483647");
               1: send_text("2147483648");
               2: send_digits($urandom_range(13, 10));
               default: send_digits($urandom_range(4, 1));
            endcase
         end
         7: begin
            send_digits($urandom_range(3, 1));
            send_item(CH_DOT, 1'b0);
            send_digits($urandom_range(3, 1));
         end
         8: begin
            send_digits($urandom_range(3, 1));
            send_item(CH_DOT, 1'b0);
            if ($urandom_range(3, 0) == 0) send_end();
            else send_noise(1);
         end
         9, 10: begin
            send_item(name_text[$urandom_range(52, 0)], 1'b0);
            count = $urandom_range(7, 0);
            for (int i = 0; i < count; i++) send_item(name_text[$urandom_range(62, 0)], 1'b0);
         end
         11, 12: begin
            word = keyword_pool[$urandom_range(8, 0)];
            pos = $urandom_range(62, 0);
            case ($urandom_range(4, 0))
               0: word = word.substr(0, word.len() - 2);
               1: word = {word, name_text.substr(pos, pos)};
               2: word[0] = word[0] ^ 8'h20;
               default: ;
            endcase
            send_text(word);
         end
         13: send_noise(1);
         14: send_end();
         default: send_item(CH_NEWLINE, 1'b0);
      endcase
      if ($urandom_range(1, 0) != 0) send_item(CH_SPACE, 1'b0);
   endtask

   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (tokens_taken % 25 == 0) rsp_mode = $urandom_range(2, 0);
         stall = (rsp_mode == 0) ? 0 : $urandom_range(13, 0);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         tokens_taken++;
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.source_byte = '0;
      req_chan.end_of_input = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: float, held dot before a letter, comment, quote pairing,
      // odd bytes, end in idle, held dot at end, open string at end, keyword.
      send_text("7.5 3.a#z\n'b\"");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("(");
      send_end();
      send_text("3.");
      send_end();
      send_text("'q");
      send_end();
      send_text("if");
      send_end();

      while (bytes_sent + ends_sent < ITEM_TARGET) send_random_token();
      send_end();
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d source bytes and %0d end markers across random token mixes",
               bytes_sent, ends_sent);
      $display("checked %0d tokens field by field", token_count);
      if ((fail_count == 0) && (pending_count == 0))
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
